FILE: rtl/tcw_pkg.sv
// Shared types, constants and helper functions of the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int NUM_COLUMNS = 80;
  localparam int NUM_ROWS    = 25;
  localparam int CELL_COUNT  = NUM_COLUMNS * NUM_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int PTR_W       = $clog2(CELL_COUNT + 1);
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;

  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  RESET_ATTR   = 8'h07;
  localparam logic [15:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

  typedef enum logic [2:0] {
    KIND_PUT_ATTR   = 3'd0,
    KIND_PUT_DEF    = 3'd1,
    KIND_CLEAR      = 3'd2,
    KIND_SET_CURSOR = 3'd3,
    KIND_READ       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CUR_HOLD = 2'd0,
    CUR_HOME = 2'd1,
    CUR_SET  = 2'd2,
    CUR_ADV  = 2'd3
  } cur_op_e;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       char_code;
    logic [7:0]       attr_in;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             scrolled;
  } result_t;

  typedef struct packed {
    cur_op_e          op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cur_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
    logic              at_end;
  } cur_stat_t;

  function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
    return (c > LAST_COL) ? LAST_COL : c;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
    return (r > LAST_ROW) ? LAST_ROW : r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * NUM_COLUMNS + int'(c));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tcw_cursor.sv
// Cursor column and row registers with set, home and advance logic.
`timescale 1ns / 1ps
`default_nettype none
module tcw_cursor (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcw_pkg::cur_cmd_t cmd_i,
  output tcw_pkg::cur_stat_t     stat_o
);
  import tcw_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    case (cmd_i.op)
      CUR_HOLD: ;
      CUR_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      CUR_SET: begin
        col_d = clamp_col(cmd_i.col);
        row_d = clamp_row(cmd_i.row);
      end
      CUR_ADV: begin
        if (col_q >= LAST_COL) begin
          col_d = '0;
          if (row_q < LAST_ROW) begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign stat_o.col    = col_q;
  assign stat_o.row    = row_q;
  assign stat_o.addr   = cell_addr(row_q, col_q);
  assign stat_o.at_end = (col_q >= LAST_COL) && (row_q >= LAST_ROW);

endmodule
`default_nettype wire

FILE: rtl/tcw_engine.sv
// Sequencer, cell memory and shared sweep pointer for puts, scroll, clear and reads.
`timescale 1ns / 1ps
`default_nettype none
module tcw_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire tcw_pkg::item_t     item_i,
  output logic                    item_ready_o,
  input  wire logic [7:0]         default_attr_i,
  input  wire tcw_pkg::cur_stat_t cur_i,
  output tcw_pkg::cur_cmd_t       cur_cmd_o,
  input  wire logic               res_free_i,
  output logic                    res_valid_o,
  output tcw_pkg::result_t        res_o
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT      = 8'b0000_0001,
    ST_IDLE      = 8'b0000_0010,
    ST_PUT       = 8'b0000_0100,
    ST_SCROLL    = 8'b0000_1000,
    ST_FILL      = 8'b0001_0000,
    ST_READ      = 8'b0010_0000,
    ST_READ_WAIT = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic              copy_v_q, copy_v_d;
  item_t             item_q;
  logic              scrolled_q, scrolled_d;
  logic [15:0]       cell_q, cell_d;

  logic [15:0]       mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       rdata_q;
  logic              accept;
  logic              ptr_last;

  assign accept   = item_valid_i && (state_q == ST_IDLE);
  assign ptr_last = (ptr_q == PTR_W'(CELL_COUNT - 1));

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    copy_v_d   = 1'b0;
    scrolled_d = scrolled_q;
    cell_d     = cell_q;
    mem_we     = 1'b0;
    mem_waddr  = ptr_q[ADDR_W-1:0];
    mem_wdata  = {default_attr_i, SPACE_CODE};
    mem_raddr  = ptr_q[ADDR_W-1:0];
    cur_cmd_o  = '{op: CUR_HOLD, col: item_q.column, row: item_q.row};

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        ptr_d     = ptr_q + PTR_W'(1);
        if (ptr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scrolled_d = 1'b0;
          cell_d     = '0;
          case (item_i.kind)
            KIND_PUT_ATTR, KIND_PUT_DEF: state_d = ST_PUT;
            KIND_CLEAR: begin
              ptr_d   = '0;
              state_d = ST_FILL;
            end
            KIND_SET_CURSOR: state_d = ST_DONE;
            KIND_READ:       state_d = ST_READ;
            default:         state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_i.addr;
        mem_wdata = {(item_q.kind == KIND_PUT_ATTR) ? item_q.attr_in : default_attr_i,
                     item_q.char_code};
        cur_cmd_o.op = CUR_ADV;
        if (cur_i.at_end) begin
          scrolled_d = 1'b1;
          ptr_d      = PTR_W'(NUM_COLUMNS);
          state_d    = ST_SCROLL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        mem_we    = copy_v_q;
        mem_waddr = ADDR_W'(ptr_q - PTR_W'(NUM_COLUMNS + 1));
        mem_wdata = rdata_q;
        if (ptr_q == PTR_W'(CELL_COUNT)) begin
          ptr_d   = PTR_W'(CELL_COUNT - NUM_COLUMNS);
          state_d = ST_FILL;
        end else begin
          copy_v_d = 1'b1;
          ptr_d    = ptr_q + PTR_W'(1);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + PTR_W'(1);
        if (ptr_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        mem_raddr = cell_addr(clamp_row(item_q.row), clamp_col(item_q.column));
        state_d   = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        cell_d  = rdata_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (accept && (item_i.kind == KIND_CLEAR)) begin
      cur_cmd_o.op = CUR_HOME;
    end else if (accept && (item_i.kind == KIND_SET_CURSOR)) begin
      cur_cmd_o = '{op: CUR_SET, col: item_i.column, row: item_i.row};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      ptr_q      <= '0;
      copy_v_q   <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      copy_v_q   <= copy_v_d;
      scrolled_q <= scrolled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign item_ready_o        = (state_q == ST_IDLE);
  assign res_valid_o         = (state_q == ST_DONE);
  assign res_o.cursor_column = cur_i.col;
  assign res_o.cursor_row    = cur_i.row;
  assign res_o.cell_char     = cell_q[7:0];
  assign res_o.cell_attr     = cell_q[15:8];
  assign res_o.scrolled      = scrolled_q;

endmodule
`default_nettype wire

FILE: rtl/text_console_writer.sv
// Top level of the text console writer: configuration register and output register.
// The screen holds a grid of character cells, each an 8-bit code and an 8-bit attribute,
// and a cursor. After reset the block runs a clearing pass of one cell a cycle over
// the 2000 cells of the 80 by 25 screen and takes no item until it has finished;
// configuration writes are taken during it. A put that scrolls is followed by a row
// copy and a bottom-row fill, one cell a cycle through the single write port of the
// cell memory, and a clear sweeps all cells the same way. The result sits in an output
// register, so the next item is taken while a finished result waits for transfer.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tcw_pkg::item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tcw_pkg::result_t      out_result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [7:0]       cfg_wdata_i
);
  import tcw_pkg::*;

  logic      [7:0] default_attr_q;
  logic            item_ready;
  cur_cmd_t        cur_cmd;
  cur_stat_t       cur_stat;
  logic            res_valid;
  logic            res_free;
  result_t         res;
  logic            out_valid_q;
  result_t         out_q;

  assign res_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !item_ready;

  tcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .stat_o (cur_stat)
  );

  tcw_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_valid_i),
    .item_i         (in_item_i),
    .item_ready_o   (item_ready),
    .default_attr_i (default_attr_q),
    .cur_i          (cur_stat),
    .cur_cmd_o      (cur_cmd),
    .res_free_i     (res_free),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr_q <= RESET_ATTR;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        default_attr_q <= cfg_wdata_i;
      end
      if (res_valid && res_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule
`default_nettype wire
